// ----- design/mpmc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the masked page mosaic combiner.
package mpmc_pkg;

    localparam int PAGES          = 64;
    localparam int MAX_ROWS       = 16;
    localparam int MAX_ROW_LENGTH = 64;
    localparam int SAMPLE_BITS    = 32;
    localparam int MASK_BITS      = 7;

    localparam int PAGE_BITS   = $clog2(PAGES);
    localparam int ROW_BITS    = $clog2(MAX_ROWS);
    localparam int COLUMN_BITS = $clog2(MAX_ROW_LENGTH);
    localparam int ADDR_BITS   = PAGE_BITS + ROW_BITS + COLUMN_BITS;
    localparam int STORE_DEPTH = PAGES * MAX_ROWS * MAX_ROW_LENGTH;

    localparam int ROW_LENGTH_BITS    = 7;
    localparam int ROWS_PER_PAGE_BITS = 5;
    localparam int CFG_DATA_BITS      = 7;

    localparam logic [ROW_LENGTH_BITS-1:0] ROW_LENGTH_RESET =
        ROW_LENGTH_BITS'(MAX_ROW_LENGTH);
    localparam logic [ROWS_PER_PAGE_BITS-1:0] ROWS_PER_PAGE_RESET =
        ROWS_PER_PAGE_BITS'(MAX_ROWS);

    typedef enum logic {
        CFG_ROW_LENGTH    = 1'b0,
        CFG_ROWS_PER_PAGE = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic [MASK_BITS-1:0]          mask;
    } t_pixel;

endpackage

// ----- design/masked_page_mosaic_combine.sv -----
`timescale 1ns / 1ps
// Masked page mosaic combiner: top level with read-modify-write control.
// The result strobe follows an accepted item through r_s1_valid and then r_out_valid.
// Throughput: one item per cycle; the pixel memory is read at acceptance and
// written in the next cycle, and a write forwarding register serves an item that
// reads the entry written in the same cycle. The receiver cannot stall.
// Reset clears the page visited flags and the pipeline valid bits and sets the
// registers to 64 pixels per row and 16 rows per page; pixel memory is not cleared.
module masked_page_mosaic_combine (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      start,
    output logic                                      busy,
    input  logic [mpmc_pkg::PAGE_BITS-1:0]            i_page,
    input  logic [mpmc_pkg::ROW_BITS-1:0]             i_row,
    input  logic [mpmc_pkg::COLUMN_BITS-1:0]          i_column,
    input  logic signed [mpmc_pkg::SAMPLE_BITS-1:0]   i_sample_value,
    input  logic [mpmc_pkg::MASK_BITS-1:0]            i_mask_value,
    input  logic                                      i_cfg_we,
    input  logic                                      i_cfg_index,
    input  logic [mpmc_pkg::CFG_DATA_BITS-1:0]        i_cfg_data,
    output logic                                      o_valid,
    output logic signed [mpmc_pkg::SAMPLE_BITS-1:0]   o_combined_value,
    output logic [mpmc_pkg::MASK_BITS-1:0]            o_combined_mask,
    output logic                                      o_page_complete
);
    import mpmc_pkg::*;

    logic [ROW_LENGTH_BITS-1:0]    r_row_length;
    logic [ROWS_PER_PAGE_BITS-1:0] r_rows_per_page;
    logic [PAGES-1:0]              r_visited;

    logic                 r_s1_valid;
    logic [ADDR_BITS-1:0] r_s1_addr;
    logic [PAGE_BITS-1:0] r_s1_page;
    logic                 r_s1_last;
    t_pixel               r_s1_new;

    logic                 r_fw_valid;
    logic [ADDR_BITS-1:0] r_fw_addr;
    t_pixel               r_fw_data;

    logic                 r_out_valid;
    t_pixel               r_out_pixel;
    logic                 r_out_complete;

    logic                          accept;
    logic [ADDR_BITS-1:0]          in_addr;
    logic [ROW_LENGTH_BITS-1:0]    row_length_eff;
    logic [ROWS_PER_PAGE_BITS-1:0] rows_eff;
    logic                          in_last;
    t_pixel                        rd_data;
    t_pixel                        stored;
    t_pixel                        result;

    assign busy    = 1'b0;
    assign accept  = start && !busy;
    assign in_addr = {i_page, i_row, i_column};

    always_comb begin
        if (r_row_length == '0) begin
            row_length_eff = ROW_LENGTH_BITS'(1);
        end else if (r_row_length > ROW_LENGTH_BITS'(MAX_ROW_LENGTH)) begin
            row_length_eff = ROW_LENGTH_BITS'(MAX_ROW_LENGTH);
        end else begin
            row_length_eff = r_row_length;
        end

        if (r_rows_per_page == '0) begin
            rows_eff = ROWS_PER_PAGE_BITS'(1);
        end else if (r_rows_per_page > ROWS_PER_PAGE_BITS'(MAX_ROWS)) begin
            rows_eff = ROWS_PER_PAGE_BITS'(MAX_ROWS);
        end else begin
            rows_eff = r_rows_per_page;
        end

        in_last = ({1'b0, i_column} == row_length_eff - ROW_LENGTH_BITS'(1))
               && ({1'b0, i_row} == rows_eff - ROWS_PER_PAGE_BITS'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_length    <= ROW_LENGTH_RESET;
            r_rows_per_page <= ROWS_PER_PAGE_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_ROW_LENGTH:    r_row_length <= i_cfg_data[ROW_LENGTH_BITS-1:0];
                CFG_ROWS_PER_PAGE: r_rows_per_page <= i_cfg_data[ROWS_PER_PAGE_BITS-1:0];
                default:           r_row_length <= r_row_length;
            endcase
        end
    end

    mpmc_store u_store (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (in_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (r_s1_valid),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (result)
    );

    assign stored = (r_fw_valid && r_fw_addr == r_s1_addr) ? r_fw_data : rd_data;

    mpmc_combine u_combine (
        .i_visited (r_visited[r_s1_page]),
        .i_stored  (stored),
        .i_new     (r_s1_new),
        .o_result  (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_fw_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_visited   <= '0;
        end else begin
            r_s1_valid  <= accept;
            r_out_valid <= r_s1_valid;
            if (r_s1_valid) begin
                r_fw_valid <= 1'b1;
                if (r_s1_last) begin
                    r_visited[r_s1_page] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_addr       <= in_addr;
            r_s1_page       <= i_page;
            r_s1_last       <= in_last;
            r_s1_new.sample <= i_sample_value;
            r_s1_new.mask   <= i_mask_value;
        end
        if (r_s1_valid) begin
            r_fw_addr      <= r_s1_addr;
            r_fw_data      <= result;
            r_out_pixel    <= result;
            r_out_complete <= r_s1_last;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_combined_value = r_out_pixel.sample;
    assign o_combined_mask  = r_out_pixel.mask;
    assign o_page_complete  = r_out_complete;

`ifndef SYNTH
    a_result_follows_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##2 o_valid)
        else $error("Accepted item produced no result two cycles later.");

    a_forward_tracks_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |=> (r_fw_valid && r_fw_addr == $past(r_s1_addr)))
        else $error("Forwarding register does not hold the last write.");

    a_last_marks_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_last) |=> r_visited[$past(r_s1_page)])
        else $error("Last pixel of a page did not set its visited flag.");

    a_complete_only_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_last) |=> (o_valid && o_page_complete))
        else $error("Page completion not reported with its result.");
`endif

endmodule

// ----- design/mpmc_store.sv -----
`timescale 1ns / 1ps
// Mosaic pixel memory with one write port and one registered read port.
module mpmc_store (
    input  logic                          i_clk,
    input  logic                          i_rd_en,
    input  logic [mpmc_pkg::ADDR_BITS-1:0] i_rd_addr,
    output mpmc_pkg::t_pixel              o_rd_data,
    input  logic                          i_wr_en,
    input  logic [mpmc_pkg::ADDR_BITS-1:0] i_wr_addr,
    input  mpmc_pkg::t_pixel              i_wr_data
);
    import mpmc_pkg::*;

    t_pixel r_mem [STORE_DEPTH];
    t_pixel r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- design/mpmc_combine.sv -----
`timescale 1ns / 1ps
// Combining rule for one stored pixel and one new pixel.
module mpmc_combine (
    input  logic             i_visited,
    input  mpmc_pkg::t_pixel i_stored,
    input  mpmc_pkg::t_pixel i_new,
    output mpmc_pkg::t_pixel o_result
);
    import mpmc_pkg::*;

    logic [SAMPLE_BITS:0] sample_sum;
    logic [MASK_BITS:0]   mask_sum;
    logic                 stored_cov;
    logic                 new_cov;
    t_pixel               average;

    always_comb begin
        sample_sum = {i_stored.sample[SAMPLE_BITS-1], i_stored.sample}
                   + {i_new.sample[SAMPLE_BITS-1], i_new.sample};
        mask_sum   = {1'b0, i_stored.mask} + {1'b0, i_new.mask};
        average.sample = sample_sum[SAMPLE_BITS:1];
        average.mask   = mask_sum[MASK_BITS:1];
        stored_cov = (i_stored.mask != '0);
        new_cov    = (i_new.mask != '0);

        if (!i_visited) begin
            o_result = i_new;
        end else if (stored_cov == new_cov) begin
            o_result = average;
        end else if (new_cov) begin
            o_result = i_new;
        end else begin
            o_result = i_stored;
        end
    end

endmodule

// ----- test/masked_page_mosaic_combine_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the masked page mosaic combiner with a pixel predictor.
module masked_page_mosaic_combine_test;

    import mpmc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        logic [PAGE_BITS-1:0]          page;
        logic [ROW_BITS-1:0]           row;
        logic [COLUMN_BITS-1:0]        column;
        logic signed [SAMPLE_BITS-1:0] sample;
        logic [MASK_BITS-1:0]          mask;
    } pixel_item_t;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] value;
        logic [MASK_BITS-1:0]          mask;
        logic                          complete;
    } combined_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [PAGE_BITS-1:0] i_page = '0;
    logic [ROW_BITS-1:0] i_row = '0;
    logic [COLUMN_BITS-1:0] i_column = '0;
    logic signed [SAMPLE_BITS-1:0] i_sample_value = '0;
    logic [MASK_BITS-1:0] i_mask_value = '0;
    logic i_cfg_we = 1'b0;
    logic i_cfg_index = 1'b0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;
    logic o_valid;
    logic signed [SAMPLE_BITS-1:0] o_combined_value;
    logic [MASK_BITS-1:0] o_combined_mask;
    logic o_page_complete;

    masked_page_mosaic_combine dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_page           (i_page),
        .i_row            (i_row),
        .i_column         (i_column),
        .i_sample_value   (i_sample_value),
        .i_mask_value     (i_mask_value),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_valid          (o_valid),
        .o_combined_value (o_combined_value),
        .o_combined_mask  (o_combined_mask),
        .o_page_complete  (o_page_complete)
    );

    always #6 i_clk = ~i_clk;

    pixel_item_t pending_pixels[$];
    combined_t   expected_pixels[$];
    int          fail_count = 0;
    int          items_queued = 0;
    int          cycle_count = 0;
    int          burst_left = 0;
    int          gap_left = 0;

    logic [ROW_LENGTH_BITS-1:0]    cfg_row_length = ROW_LENGTH_RESET;
    logic [ROWS_PER_PAGE_BITS-1:0] cfg_rows_per_page = ROWS_PER_PAGE_RESET;

    logic signed [SAMPLE_BITS-1:0] mosaic_sample[STORE_DEPTH];
    logic [MASK_BITS-1:0]          mosaic_mask[STORE_DEPTH];
    bit                            mosaic_visited[PAGES];

    bit                            plan_written[STORE_DEPTH];
    bit                            plan_visited[PAGES];
    logic [ROW_BITS+COLUMN_BITS-1:0] plan_anchor[PAGES];

    function automatic int unsigned used_size(int unsigned raw, int unsigned limit);
        if (raw == 0) return 1;
        return (raw > limit) ? limit : raw;
    endfunction

    function automatic int unsigned used_row_length();
        return used_size(cfg_row_length, MAX_ROW_LENGTH);
    endfunction

    function automatic int unsigned used_rows();
        return used_size(cfg_rows_per_page, MAX_ROWS);
    endfunction

    function automatic bit is_last_pixel(int unsigned row, int unsigned column);
        return (row == used_rows() - 1) && (column == used_row_length() - 1);
    endfunction

    function automatic combined_t combine_pixel(pixel_item_t px);
        logic [ADDR_BITS-1:0]          addr;
        logic signed [SAMPLE_BITS:0]   sum;
        logic [MASK_BITS:0]            mask_sum;
        logic signed [SAMPLE_BITS-1:0] old_sample;
        logic [MASK_BITS-1:0]          old_mask;
        combined_t                     res;
        addr = {px.page, px.row, px.column};
        if (!mosaic_visited[px.page]) begin
            mosaic_sample[addr] = px.sample;
            mosaic_mask[addr] = px.mask;
        end else begin
            old_sample = mosaic_sample[addr];
            old_mask = mosaic_mask[addr];
            if ((old_mask != 0) == (px.mask != 0)) begin
                sum = {old_sample[SAMPLE_BITS-1], old_sample}
                    + {px.sample[SAMPLE_BITS-1], px.sample};
                mask_sum = {1'b0, old_mask} + {1'b0, px.mask};
                mosaic_sample[addr] = sum[SAMPLE_BITS:1];
                mosaic_mask[addr] = mask_sum[MASK_BITS:1];
            end else if (px.mask != 0) begin
                mosaic_sample[addr] = px.sample;
                mosaic_mask[addr] = px.mask;
            end
        end
        res.complete = is_last_pixel(px.row, px.column);
        if (res.complete) mosaic_visited[px.page] = 1'b1;
        res.value = mosaic_sample[addr];
        res.mask = mosaic_mask[addr];
        return res;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 5))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return '0;
            3: return -32'sd1;
            4: return $signed(32'($urandom_range(0, 8)) - 32'd4);
            default: return $signed($urandom);
        endcase
    endfunction

    function automatic logic [MASK_BITS-1:0] pick_mask();
        case ($urandom_range(0, 9))
            0, 1, 2: return '0;
            3: return 7'd127;
            4: return 7'd1;
            default: return MASK_BITS'($urandom_range(1, 126));
        endcase
    endfunction

    // A visited page may only combine entries that were stored before.
    task automatic offer_pixel(int unsigned page, int unsigned row, int unsigned column,
                               logic signed [SAMPLE_BITS-1:0] sample,
                               logic [MASK_BITS-1:0] mask);
        pixel_item_t          px;
        logic [ADDR_BITS-1:0] addr;
        px.page = PAGE_BITS'(page);
        px.row = ROW_BITS'(row);
        px.column = COLUMN_BITS'(column);
        px.sample = sample;
        px.mask = mask;
        addr = {px.page, px.row, px.column};
        if (plan_visited[page] && !plan_written[addr]) return;
        if (!plan_visited[page]) begin
            plan_written[addr] = 1'b1;
            plan_anchor[page] = {px.row, px.column};
        end
        if (is_last_pixel(row, column)) plan_visited[page] = 1'b1;
        pending_pixels.push_back(px);
        items_queued++;
    endtask

    task automatic offer_random(int unsigned page, int unsigned row, int unsigned column);
        offer_pixel(page, row, column, pick_sample(), pick_mask());
    endtask

    task automatic sweep_page(int unsigned page);
        int unsigned rl;
        int unsigned rp;
        int unsigned count;
        rl = used_row_length();
        rp = used_rows();
        if (rl * rp <= 24) begin
            for (int r = 0; r < rp; r++) begin
                for (int c = 0; c < rl; c++) begin
                    if ($urandom_range(0, 4) != 0) offer_random(page, r, c);
                end
            end
        end else begin
            count = $urandom_range(3, 10);
            for (int k = 0; k < count; k++) begin
                if ($urandom_range(0, 1) == 0)
                    offer_random(page, $urandom_range(0, (rp < 4 ? rp : 4) - 1),
                                 $urandom_range(0, (rl < 4 ? rl : 4) - 1));
                else
                    offer_random(page, $urandom_range(0, rp - 1), $urandom_range(0, rl - 1));
            end
            if (plan_visited[page])
                offer_random(page, plan_anchor[page][ROW_BITS+COLUMN_BITS-1:COLUMN_BITS],
                             plan_anchor[page][COLUMN_BITS-1:0]);
            if ($urandom_range(0, 3) != 0) offer_random(page, rp - 1, rl - 1);
        end
    endtask

    task automatic run_random(int target);
        int goal;
        goal = items_queued + target;
        while (items_queued < goal) begin
            if ($urandom_range(0, 9) < 7)
                sweep_page($urandom_range(0, PAGES - 1));
            else
                offer_random($urandom_range(0, PAGES - 1), $urandom_range(0, MAX_ROWS - 1),
                             $urandom_range(0, MAX_ROW_LENGTH - 1));
        end
    endtask

    task automatic wait_drained();
        while (pending_pixels.size() != 0 || expected_pixels.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_reg index, logic [CFG_DATA_BITS-1:0] data);
        wait_drained();
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        if (index == CFG_ROW_LENGTH)
            cfg_row_length = data[ROW_LENGTH_BITS-1:0];
        else
            cfg_rows_per_page = data[ROWS_PER_PAGE_BITS-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_shape(logic [CFG_DATA_BITS-1:0] row_length,
                             logic [CFG_DATA_BITS-1:0] rows);
        write_reg(CFG_ROW_LENGTH, row_length);
        write_reg(CFG_ROWS_PER_PAGE, rows);
    endtask

    always @(posedge i_clk) begin : item_driver
        bit taken;
        taken = start && !busy;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (taken) begin
                expected_pixels.push_back(combine_pixel(pending_pixels.pop_front()));
            end
            if (!start || taken) begin
                if (gap_left > 0) begin
                    gap_left = gap_left - 1;
                    start <= 1'b0;
                end else if (pending_pixels.size() > 0) begin
                    i_page <= pending_pixels[0].page;
                    i_row <= pending_pixels[0].row;
                    i_column <= pending_pixels[0].column;
                    i_sample_value <= pending_pixels[0].sample;
                    i_mask_value <= pending_pixels[0].mask;
                    start <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left = burst_left - 1;
                    end
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : result_monitor
        combined_t want;
        if (i_rst_n && o_valid) begin
            if (expected_pixels.size() == 0) begin
                $error("unexpected result: combined_value %0d", o_combined_value);
                fail_count++;
            end else begin
                want = expected_pixels.pop_front();
                if (o_combined_value !== want.value) begin
                    $error("combined_value: expected %0d, got %0d", want.value,
                           o_combined_value);
                    fail_count++;
                end
                if (o_combined_mask !== want.mask) begin
                    $error("combined_mask: expected %0d, got %0d", want.mask, o_combined_mask);
                    fail_count++;
                end
                if (o_page_complete !== want.complete) begin
                    $error("page_complete: expected %0d, got %0d", want.complete,
                           o_page_complete);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Full page shape from reset: first pass stores, the last pixel marks the page.
        offer_pixel(0, 0, 0, 32'sh7FFF_FFFF, 7'd127);
        offer_pixel(0, 0, 1, 32'sh8000_0000, 7'd0);
        offer_pixel(0, 0, 2, -32'sd1, 7'd1);
        offer_pixel(0, 15, 63, 32'sd1, 7'd0);
        offer_pixel(0, 0, 0, 32'sh7FFF_FFFF, 7'd127);
        offer_pixel(0, 0, 1, 32'sh8000_0000, 7'd0);
        offer_pixel(0, 0, 2, 32'sd0, 7'd3);
        offer_pixel(0, 15, 63, 32'sh8000_0000, 7'd5);
        offer_pixel(0, 0, 0, 32'sd0, 7'd0);
        offer_pixel(0, 0, 1, 32'sh7FFF_FFFF, 7'd127);
        offer_pixel(0, 15, 63, 32'sh7FFF_FFFF, 7'd127);
        offer_pixel(63, 15, 0, 32'shAAAA_AAAA, 7'h2A);
        offer_pixel(63, 0, 63, 32'sh5555_5555, 7'h55);
        offer_pixel(63, 15, 63, -32'sd3, 7'd126);
        offer_pixel(63, 15, 0, 32'sh5555_5555, 7'h55);
        offer_pixel(63, 0, 63, 32'shAAAA_AAAA, 7'd0);
        offer_pixel(63, 15, 63, 32'sd2, 7'd1);
        offer_pixel(42, 10, 21, -32'sd7, 7'd9);
        offer_pixel(21, 5, 42, 32'sd5, 7'd0);
        run_random(40);

        set_shape(7'd4, 7'd2);
        offer_pixel(1, 1, 7, 32'sh7FFF_FFFF, 7'd127);
        offer_pixel(1, 9, 2, 32'sh8000_0000, 7'd0);
        offer_pixel(1, 1, 3, 32'sd9, 7'd4);
        offer_pixel(1, 1, 7, -32'sd1, 7'd1);
        offer_pixel(1, 9, 2, 32'sd1, 7'd8);
        run_random(80);

        set_shape(7'd1, 7'd1);
        run_random(60);

        set_shape(7'd0, 7'd0);
        run_random(60);

        set_shape(7'd127, 7'd31);
        run_random(60);

        set_shape(7'd3, 7'h45);
        run_random(70);

        set_shape(7'd64, 7'd16);
        run_random(50);

        for (int k = 0; k < 4; k++) begin
            set_shape(CFG_DATA_BITS'($urandom_range(1, 8)), CFG_DATA_BITS'($urandom_range(1, 4)));
            run_random(50);
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/mpmc_pkg.sv
design/mpmc_store.sv
design/mpmc_combine.sv
design/masked_page_mosaic_combine.sv
test/masked_page_mosaic_combine_test.sv
